>>> src/svat_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// svat_pkg: shared types and constants for the sprite vertex transform
// Request payloads, register map, sine polynomial constants and datapath
// widths used by every module of the block.
// ============================================================================
package svat_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int COORD_W = 32;
    localparam int TRIG_W  = 16;

    // sine/cosine pipeline depth, from angle register to sine/cosine output
    localparam int TRIG_LAT = 6;

    // scaled coordinate width after the clamp to +-2^47
    localparam int XS_W  = 49;
    localparam int ROT_W = XS_W + TRIG_W;
    localparam int SUM_W = ROT_W + 1 - 15;

    localparam logic signed [63:0] PROD_LIM = 64'sd140737488355328;

    // polynomial constants in Q2.30
    localparam logic [30:0] POLY_A = 31'd1686629713;
    localparam logic [29:0] POLY_B = 30'd688904866;
    localparam logic [26:0] POLY_C = 27'd76016977;

    localparam logic [15:0] Q15_MAX = 16'd32767;

    localparam logic signed [COORD_W-1:0] W_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] W_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REG_SCALE_X        = 3'd0,
        REG_SCALE_Y        = 3'd1,
        REG_ROTATION_ANGLE = 3'd2,
        REG_OFFSET_X       = 3'd3,
        REG_OFFSET_Y       = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] local_x;
        logic signed [COORD_W-1:0] local_y;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
        logic                      saturated;
    } world_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] scale_x;
        logic signed [COORD_W-1:0] scale_y;
        logic [15:0]               rotation_angle;
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
    } cfg_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_val;
        logic signed [TRIG_W-1:0] cos_val;
        logic                     ready;
    } trig_t;

    localparam cfg_t CFG_RESET = '{
        scale_x:        32'sd65536,
        scale_y:        32'sd65536,
        rotation_angle: 16'd0,
        offset_x:       32'sd0,
        offset_y:       32'sd0
    };

endpackage

>>> src/svat_cfg.sv
`timescale 1ns / 1ps
// ============================================================================
// svat_cfg: configuration register file
// APB-style slave holding scale, rotation angle and offset registers.
// ============================================================================
module svat_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [svat_pkg::PADDR_W-1:0] paddr,
    input  logic [svat_pkg::PDATA_W-1:0] pwdata,
    output logic [svat_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output svat_pkg::cfg_t              cfg,
    output logic                        ang_load
);
    import svat_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        ang_load = 1'b0;
        if (wr_en)
        begin
            unique case (idx)
                REG_SCALE_X:        cfg_next.scale_x  = pwdata;
                REG_SCALE_Y:        cfg_next.scale_y  = pwdata;
                REG_ROTATION_ANGLE:
                begin
                    cfg_next.rotation_angle = pwdata[15:0];
                    ang_load                = 1'b1;
                end
                REG_OFFSET_X:       cfg_next.offset_x = pwdata;
                REG_OFFSET_Y:       cfg_next.offset_y = pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SCALE_X:        prdata = cfg_reg.scale_x;
            REG_SCALE_Y:        prdata = cfg_reg.scale_y;
            REG_ROTATION_ANGLE: prdata = {16'd0, cfg_reg.rotation_angle};
            REG_OFFSET_X:       prdata = cfg_reg.offset_x;
            REG_OFFSET_Y:       prdata = cfg_reg.offset_y;
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    a_angle_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && idx == REG_ROTATION_ANGLE |=>
            cfg_reg.rotation_angle == $past(pwdata[15:0]) && $past(ang_load))
        else $error("rotation angle write not taken");

endmodule

>>> src/svat_sincos.sv
`timescale 1ns / 1ps
// ============================================================================
// svat_sincos: sine and cosine pipeline
// Six-stage polynomial evaluator for sine and cosine of the rotation angle
// in Q1.15, with a settle counter that flags when the outputs are current.
// ============================================================================
module svat_sincos
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [15:0]    angle,
    input  logic           ang_load,
    output svat_pkg::trig_t trig
);
    import svat_pkg::*;

    localparam int RW    = ANGLE_BITS - 2;
    localparam int ZSH   = 17 - ANGLE_BITS;
    localparam int CNT_W = $clog2(TRIG_LAT + 1);
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << RW;

    logic [ANGLE_BITS-1:0] lane_ang [2];
    logic [1:0]            quad     [2];
    logic [RW-1:0]         rem      [2];
    logic [15:0]           z_raw    [2];

    logic [15:0] z1_next [2];
    logic        n1_next [2];
    logic [31:0] prod_zz [2];
    logic [15:0] zz2_next [2];
    logic [42:0] prod_c  [2];
    logic [29:0] t3_next [2];
    logic [45:0] prod_t  [2];
    logic [30:0] t4_next [2];
    logic [46:0] prod_s  [2];
    logic [31:0] s5_next [2];
    logic [32:0] rnd     [2];
    logic [17:0] mag     [2];
    logic [15:0] mag_c   [2];
    logic signed [TRIG_W-1:0] out_next [2];

    logic [15:0] z1_reg  [2];
    logic        n1_reg  [2];
    logic [15:0] z2_reg  [2];
    logic [15:0] zz2_reg [2];
    logic        n2_reg  [2];
    logic [15:0] z3_reg  [2];
    logic [15:0] zz3_reg [2];
    logic [29:0] t3_reg  [2];
    logic        n3_reg  [2];
    logic [15:0] z4_reg  [2];
    logic [30:0] t4_reg  [2];
    logic        n4_reg  [2];
    logic [31:0] s5_reg  [2];
    logic        n5_reg  [2];
    logic signed [TRIG_W-1:0] out_reg [2];

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        lane_ang[0] = angle[ANGLE_BITS-1:0];
        lane_ang[1] = angle[ANGLE_BITS-1:0] + QUARTER;
        for (int l = 0; l < 2; l++)
        begin
            quad[l]  = lane_ang[l][ANGLE_BITS-1:ANGLE_BITS-2];
            rem[l]   = lane_ang[l][RW-1:0];
            z_raw[l] = {1'b0, rem[l], {ZSH{1'b0}}};
            z1_next[l] = quad[l][0] ? (16'd32768 - z_raw[l]) : z_raw[l];
            n1_next[l] = quad[l][1];

            prod_zz[l]  = 32'(z1_reg[l]) * 32'(z1_reg[l]);
            zz2_next[l] = prod_zz[l][30:15];

            prod_c[l]  = 43'(POLY_C) * 43'(zz2_reg[l]);
            t3_next[l] = POLY_B - {2'b00, prod_c[l][42:15]};

            prod_t[l]  = 46'(t3_reg[l]) * 46'(zz3_reg[l]);
            t4_next[l] = POLY_A - prod_t[l][45:15];

            prod_s[l]  = 47'(t4_reg[l]) * 47'(z4_reg[l]);
            s5_next[l] = prod_s[l][46:15];

            rnd[l]   = 33'(s5_reg[l]) + 33'd16384;
            mag[l]   = rnd[l][32:15];
            mag_c[l] = (mag[l] > 18'(Q15_MAX)) ? Q15_MAX : mag[l][15:0];
            out_next[l] = n5_reg[l] ? -$signed(mag_c[l]) : $signed(mag_c[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            z1_reg[l]  <= z1_next[l];
            n1_reg[l]  <= n1_next[l];
            z2_reg[l]  <= z1_reg[l];
            zz2_reg[l] <= zz2_next[l];
            n2_reg[l]  <= n1_reg[l];
            z3_reg[l]  <= z2_reg[l];
            zz3_reg[l] <= zz2_reg[l];
            t3_reg[l]  <= t3_next[l];
            n3_reg[l]  <= n2_reg[l];
            z4_reg[l]  <= z3_reg[l];
            t4_reg[l]  <= t4_next[l];
            n4_reg[l]  <= n3_reg[l];
            s5_reg[l]  <= s5_next[l];
            n5_reg[l]  <= n4_reg[l];
            out_reg[l] <= out_next[l];
        end
    end

    // hold ready low until a new angle has passed every stage
    always_comb
    begin
        if (ang_load)
        begin
            cnt_next = CNT_W'(TRIG_LAT);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_W'(TRIG_LAT);
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign trig.sin_val = out_reg[0];
    assign trig.cos_val = out_reg[1];
    assign trig.ready   = (cnt_reg == '0);

    a_load_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        ang_load |=> !trig.ready)
        else $error("angle load did not drop ready");

    a_ready_stable: assert property (@(posedge clk) disable iff (!rst_n)
        trig.ready && $past(trig.ready) |-> $stable(trig.sin_val) && $stable(trig.cos_val))
        else $error("sine or cosine moved while ready");

endmodule

>>> src/svat_pipe.sv
`timescale 1ns / 1ps
// ============================================================================
// svat_pipe: four-stage transform datapath
// Scale multiply, clamp and rotation multiply, rotation sum, offset add with
// saturation into the output register; valid bits and stall travel along.
// ============================================================================
module svat_pipe
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    output logic              vertex_stall,
    input  svat_pkg::vertex_t vertex,
    output logic              world_valid,
    input  logic              world_stall,
    output svat_pkg::world_t  world,
    input  svat_pkg::cfg_t    cfg,
    input  svat_pkg::trig_t   trig
);
    import svat_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ready1, ready2, ready3, ready4;
    logic accept;

    logic signed [63:0]      px_reg, py_reg, px_next, py_next;
    logic signed [63:0]      xs_sh, ys_sh;
    logic signed [XS_W-1:0]  xs_cl, ys_cl;
    logic signed [ROT_W-1:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [ROT_W-1:0] pxc_next, pys_next, pxs_next, pyc_next;
    logic signed [ROT_W:0]   rx_full, ry_full;
    logic signed [SUM_W-1:0] rx_reg, ry_reg, rx_next, ry_next;
    logic signed [SUM_W:0]   wx, wy;
    logic                    ovx, ovy;
    world_t                  world_reg, world_next;

    assign ready4       = !v4_reg || !world_stall;
    assign ready3       = !v3_reg || ready4;
    assign ready2       = !v2_reg || ready3;
    assign ready1       = !v1_reg || ready2;
    assign vertex_stall = !ready1 || !trig.ready;
    assign accept       = vertex_valid && !vertex_stall;

    always_comb
    begin
        px_next = 64'(vertex.local_x) * 64'(cfg.scale_x);
        py_next = 64'(vertex.local_y) * 64'(cfg.scale_y);

        xs_sh = px_reg >>> FRAC_BITS;
        ys_sh = py_reg >>> FRAC_BITS;
        if (xs_sh > PROD_LIM)
        begin
            xs_cl = XS_W'(PROD_LIM);
        end
        else if (xs_sh < -PROD_LIM)
        begin
            xs_cl = XS_W'(-PROD_LIM);
        end
        else
        begin
            xs_cl = XS_W'(xs_sh);
        end
        if (ys_sh > PROD_LIM)
        begin
            ys_cl = XS_W'(PROD_LIM);
        end
        else if (ys_sh < -PROD_LIM)
        begin
            ys_cl = XS_W'(-PROD_LIM);
        end
        else
        begin
            ys_cl = XS_W'(ys_sh);
        end
        pxc_next = ROT_W'(xs_cl) * ROT_W'(trig.cos_val);
        pys_next = ROT_W'(ys_cl) * ROT_W'(trig.sin_val);
        pxs_next = ROT_W'(xs_cl) * ROT_W'(trig.sin_val);
        pyc_next = ROT_W'(ys_cl) * ROT_W'(trig.cos_val);

        rx_full = (ROT_W+1)'(pxc_reg) - (ROT_W+1)'(pys_reg);
        ry_full = (ROT_W+1)'(pxs_reg) + (ROT_W+1)'(pyc_reg);
        rx_next = SUM_W'(rx_full >>> 15);
        ry_next = SUM_W'(ry_full >>> 15);

        wx  = (SUM_W+1)'(rx_reg) + (SUM_W+1)'(cfg.offset_x);
        wy  = (SUM_W+1)'(ry_reg) + (SUM_W+1)'(cfg.offset_y);
        ovx = (wx[SUM_W:COORD_W-1] != '0) && (wx[SUM_W:COORD_W-1] != '1);
        ovy = (wy[SUM_W:COORD_W-1] != '0) && (wy[SUM_W:COORD_W-1] != '1);
        world_next.world_x   = ovx ? (wx[SUM_W] ? W_MIN : W_MAX) : wx[COORD_W-1:0];
        world_next.world_y   = ovy ? (wy[SUM_W] ? W_MIN : W_MAX) : wy[COORD_W-1:0];
        world_next.saturated = ovx || ovy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= accept;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (ready2)
        begin
            pxc_reg <= pxc_next;
            pys_reg <= pys_next;
            pxs_reg <= pxs_next;
            pyc_reg <= pyc_next;
        end
        if (ready3)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
        end
        if (ready4)
        begin
            world_reg <= world_next;
        end
    end

    assign world_valid = v4_reg;
    assign world       = world_reg;

    a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        world_valid && world.saturated |->
            (world.world_x == W_MAX || world.world_x == W_MIN ||
             world.world_y == W_MAX || world.world_y == W_MIN))
        else $error("saturated flag without a clipped result");

    a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !ready4 |=> v3_reg && $stable(rx_reg) && $stable(ry_reg))
        else $error("rotation stage lost a held request");

endmodule

>>> src/sprite_vertex_affine_transform.sv
`timescale 1ns / 1ps
// ============================================================================
// sprite_vertex_affine_transform: sprite vertex scale, rotate, translate
// Maps local Q16.16 vertices to saturated world coordinates.
// ============================================================================
// Accepts one vertex request per clock while vertex_stall is low and returns
// its world position via px_reg, pxc_reg, rx_reg and a registered output;
// each of the four datapath stages (scale multiply, rotation multiply,
// rotation sum, offset add and saturation) holds its request while the stage
// after it is full and held, so empty stages close up when the output stalls.
// Sine and cosine of the rotation angle come from a six-stage polynomial
// pipeline: after reset and after every write to rotation_angle, vertex_stall
// stays high while that pipeline refills. Registers lie at byte address 4*i
// in the order scale_x, scale_y, rotation_angle, offset_x, offset_y. The user
// must write them only while no request is in flight, unchecked by the block.
module sprite_vertex_affine_transform
#(
    parameter int FRAC_BITS  = 16,
    parameter int ANGLE_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         vertex_valid,
    output logic                         vertex_stall,
    input  svat_pkg::vertex_t            vertex,
    output logic                         world_valid,
    input  logic                         world_stall,
    output svat_pkg::world_t             world,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [svat_pkg::PADDR_W-1:0] paddr,
    input  logic [svat_pkg::PDATA_W-1:0] pwdata,
    output logic [svat_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import svat_pkg::*;

    cfg_t  cfg;
    trig_t trig;
    logic  ang_load;

    svat_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .ang_load (ang_load)
    );

    svat_sincos
    #(
        .ANGLE_BITS (ANGLE_BITS)
    )
    u_sincos
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .angle    (cfg.rotation_angle),
        .ang_load (ang_load),
        .trig     (trig)
    );

    svat_pipe
    #(
        .FRAC_BITS (FRAC_BITS)
    )
    u_pipe
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .world_valid  (world_valid),
        .world_stall  (world_stall),
        .world        (world),
        .cfg          (cfg),
        .trig         (trig)
    );

endmodule
